// ===== design/rtc_pkg.sv =====
// Shared types and constants for the reaction timer controller.
package rtc_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd4;

    localparam logic [31:0] RST_SEED       = 32'd1;
    localparam logic [31:0] RST_DELAY_MIN  = 32'd50000000;
    localparam logic [31:0] RST_DELAY_MASK = 32'd67108863;
    localparam logic [31:0] RST_TIMEOUT    = 32'd200000000;
    localparam logic [31:0] RST_HOLD_TICKS = 32'd100000000;

    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    localparam logic [9:0] LED_OFF  = 10'h000;
    localparam logic [9:0] LED_GO   = 10'h020;
    localparam logic [9:0] LED_DONE = 10'h3FF;
    localparam logic [9:0] LED_MISS = 10'h001;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_DELAY   = 3'd1,
        PH_REACT   = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] delay_min;
        logic [31:0] delay_mask;
        logic [31:0] timeout;
        logic [31:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic [9:0]  leds;
        logic        display_on;
        logic [23:0] shown_count;
        logic        round_done;
        logic        missed;
    } result_t;

    function automatic logic [31:0] lfsr_advance(input logic [31:0] s);
        lfsr_advance = {1'b0, s[31:1]} ^ (s[0] ? LFSR_TAPS : 32'd0);
    endfunction

endpackage

// ===== design/rtc_cfg_regs.sv =====
// Configuration register file written through the cfg channel.
module rtc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output rtc_pkg::cfg_t                  cfg
);
    import rtc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seed       <= RST_SEED;
            cfg_reg.delay_min  <= RST_DELAY_MIN;
            cfg_reg.delay_mask <= RST_DELAY_MASK;
            cfg_reg.timeout    <= RST_TIMEOUT;
            cfg_reg.hold_ticks <= RST_HOLD_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SEED:       cfg_reg.seed       <= cfg_data;
                CFG_DELAY_MIN:  cfg_reg.delay_min  <= cfg_data;
                CFG_DELAY_MASK: cfg_reg.delay_mask <= cfg_data;
                CFG_TIMEOUT:    cfg_reg.timeout    <= cfg_data;
                CFG_HOLD_TICKS: cfg_reg.hold_ticks <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/rtc_fsm.sv =====
// Round state machine: phase, tick counter, LFSR and the per-tick result.
module rtc_fsm #(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick,
    input  logic             key_pressed,
    input  rtc_pkg::cfg_t    cfg,
    output rtc_pkg::result_t result
);
    import rtc_pkg::*;

    localparam int unsigned CMP_W = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;

    phase_t                   phase_reg,    phase_next;
    logic [31:0]              prng_reg,     prng_next;
    logic [COUNTER_WIDTH-1:0] ticks_reg,    ticks_next;
    logic [31:0]              target_reg,   target_next;
    logic [31:0]              measured_reg, measured_next;
    logic                     miss_reg,     miss_next;

    logic [COUNTER_WIDTH-1:0] ticks_inc;
    logic [CMP_W-1:0]         ticks_ext;
    logic                     hit_target;
    logic                     hit_timeout;
    logic                     hit_hold;
    logic [31:0]              lfsr_src;
    logic [31:0]              lfsr_adv;
    logic [31:0]              target_new;
    logic                     done;
    logic                     disp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            prng_reg     <= '0;
            ticks_reg    <= '0;
            target_reg   <= '0;
            measured_reg <= '0;
            miss_reg     <= 1'b0;
        end else if (tick) begin
            phase_reg    <= phase_next;
            prng_reg     <= prng_next;
            ticks_reg    <= ticks_next;
            target_reg   <= target_next;
            measured_reg <= measured_next;
            miss_reg     <= miss_next;
        end
    end

    // The counter saturates, so a bound above its maximum is never reached.
    assign ticks_inc   = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign ticks_ext   = CMP_W'(ticks_reg);
    assign hit_target  = ticks_ext >= CMP_W'(target_reg);
    assign hit_timeout = ticks_ext >= CMP_W'(cfg.timeout);
    assign hit_hold    = ticks_ext >= CMP_W'(cfg.hold_ticks);

    assign lfsr_src   = (phase_reg == PH_START) ? (cfg.seed | 32'd1) : prng_reg;
    assign lfsr_adv   = lfsr_advance(lfsr_src);
    assign target_new = cfg.delay_min + (lfsr_adv & cfg.delay_mask);

    always_comb begin
        phase_next    = phase_reg;
        prng_next     = prng_reg;
        ticks_next    = ticks_inc;
        target_next   = target_reg;
        measured_next = measured_reg;
        miss_next     = miss_reg;
        done          = 1'b0;
        case (phase_reg)
            PH_START: begin
                prng_next   = lfsr_adv;
                target_next = target_new;
                phase_next  = PH_DELAY;
                ticks_next  = '0;
            end
            PH_DELAY: begin
                if (hit_target) begin
                    phase_next = PH_REACT;
                    ticks_next = '0;
                end
            end
            PH_REACT: begin
                if (key_pressed || hit_timeout) begin
                    miss_next     = !key_pressed;
                    measured_next = ticks_ext[31:0];
                    done          = 1'b1;
                    phase_next    = PH_HOLD;
                    ticks_next    = '0;
                end
            end
            PH_HOLD: begin
                if (hit_hold) begin
                    phase_next = PH_RELEASE;
                    ticks_next = '0;
                end
            end
            default: begin
                if (!key_pressed || hit_timeout) begin
                    prng_next   = lfsr_adv;
                    target_next = target_new;
                    phase_next  = PH_DELAY;
                    ticks_next  = '0;
                end
            end
        endcase
    end

    always_comb begin
        result.leds = LED_OFF;
        disp        = 1'b0;
        case (phase_next)
            PH_REACT: begin
                result.leds = LED_GO;
            end
            PH_HOLD, PH_RELEASE: begin
                result.leds = miss_next ? LED_MISS : LED_DONE;
                disp        = 1'b1;
            end
            default: begin
                result.leds = LED_OFF;
            end
        endcase
        result.display_on  = disp;
        result.shown_count = disp ? measured_next[23:0] : 24'd0;
        result.round_done  = done;
        result.missed      = miss_next;
    end

endmodule

// ===== design/rtc_out_buf.sv =====
// Result register with a skid stage so input acceptance survives a stalled output.
module rtc_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rtc_pkg::result_t push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output rtc_pkg::result_t out_data
);
    import rtc_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,        out_next;
    result_t skid_reg,       skid_next;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !out_ready) begin
            if (push) begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = push;
            out_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== design/reaction_timer_controller.sv =====
// Top level of the reaction timer controller.
// An accepted result is registered in the output entry, or in the skid entry if m_ stalls.
// Throughput: one item per cycle while s_ready is high; a two-entry result buffer keeps
// s_ready high when the output first stalls, and drops it only when both entries hold.
// Reset: synchronous active-low aresetn restores register defaults and the start phase.
module reaction_timer_controller #(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_key_pressed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [9:0]                    m_leds,
    output logic                          m_display_on,
    output logic [23:0]                   m_shown_count,
    output logic                          m_round_done,
    output logic                          m_missed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rtc_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    accept;
    logic    space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    rtc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtc_fsm #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick        (accept),
        .key_pressed (s_key_pressed),
        .cfg         (cfg),
        .result      (step_result)
    );

    rtc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (step_result),
        .space     (space),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_leds        = out_data.leds;
    assign m_display_on  = out_data.display_on;
    assign m_shown_count = out_data.shown_count;
    assign m_round_done  = out_data.round_done;
    assign m_missed      = out_data.missed;

    a_done_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_round_done |-> m_display_on)
        else $error("Completed measurement is not displayed.");

    a_blank_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_display_on |-> m_shown_count == 24'd0)
        else $error("Blank display carries a count.");

    a_miss_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_display_on && m_missed |-> m_leds == LED_MISS)
        else $error("Missed result shows the wrong LED pattern.");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("Input stalled while the result register is empty.");

endmodule

// ===== tb/tb_reaction_timer_controller.sv =====
// Self-checking testbench for the reaction timer controller, predicting every tick's display.
`timescale 1ns / 100ps

module tb_reaction_timer_controller;
    import rtc_pkg::*;

    localparam int unsigned TICK_W = 32;
    localparam logic [63:0] TICK_MAX = (64'd1 << TICK_W) - 64'd1;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned RANDOM_TICKS = 440;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic    key;
        logic    fixed;
        result_t res;
    } tick_row_t;

    localparam result_t ANY = '0;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_key_pressed = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [9:0]           m_leds;
    logic                 m_display_on;
    logic [23:0]          m_shown_count;
    logic                 m_round_done;
    logic                 m_missed;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    cfg_t timer_cfg = '{RST_SEED, RST_DELAY_MIN, RST_DELAY_MASK, RST_TIMEOUT, RST_HOLD_TICKS};
    phase_t      stage = PH_START;
    logic [31:0] lfsr_now = '0;
    logic [63:0] stage_ticks = '0;
    logic [31:0] delay_goal = '0;
    logic [31:0] reaction_ticks = '0;
    logic        timed_out = 1'b0;

    result_t     pending_displays [$];
    int unsigned errors = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned rounds_seen = 0;
    int unsigned misses_seen = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;
    logic        src_idle = 1'b0;
    logic        sink_idle = 1'b0;

    tick_row_t directed_rows [23] = '{
        '{1'b0, 1'b1, '{LED_OFF, 1'b0, 24'd0, 1'b0, 1'b0}},
        '{1'b0, 1'b0, ANY},
        '{1'b1, 1'b1, '{LED_DONE, 1'b1, 24'd0, 1'b1, 1'b0}},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b1, '{LED_MISS, 1'b1, 24'd3, 1'b1, 1'b1}},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b1, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        '{1'b0, 1'b0, ANY},
        // A key press on the tick the timeout is reached still counts as a hit.
        '{1'b1, 1'b1, '{LED_DONE, 1'b1, 24'd3, 1'b1, 1'b0}}
    };

    reaction_timer_controller #(
        .COUNTER_WIDTH(TICK_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_key_pressed(s_key_pressed),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_leds(m_leds),
        .m_display_on(m_display_on),
        .m_shown_count(m_shown_count),
        .m_round_done(m_round_done),
        .m_missed(m_missed),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : 32'd0);
    endfunction

    function automatic void begin_round();
        lfsr_now = lfsr_step(lfsr_now);
        delay_goal = timer_cfg.delay_min + (lfsr_now & timer_cfg.delay_mask);
        stage = PH_DELAY;
        stage_ticks = '0;
    endfunction

    function automatic void bump_ticks();
        if (stage_ticks < TICK_MAX) begin
            stage_ticks = stage_ticks + 64'd1;
        end
    endfunction

    function automatic result_t timer_tick(input logic key);
        result_t shown;
        shown = '0;
        case (stage)
            PH_START: begin
                lfsr_now = timer_cfg.seed | 32'd1;
                begin_round();
            end
            PH_DELAY: begin
                if (stage_ticks >= 64'(delay_goal)) begin
                    stage = PH_REACT;
                    stage_ticks = '0;
                end else begin
                    bump_ticks();
                end
            end
            PH_REACT: begin
                if (key || stage_ticks >= 64'(timer_cfg.timeout)) begin
                    timed_out = !key;
                    reaction_ticks = stage_ticks[31:0];
                    shown.round_done = 1'b1;
                    stage = PH_HOLD;
                    stage_ticks = '0;
                end else begin
                    bump_ticks();
                end
            end
            PH_HOLD: begin
                if (stage_ticks >= 64'(timer_cfg.hold_ticks)) begin
                    stage = PH_RELEASE;
                    stage_ticks = '0;
                end else begin
                    bump_ticks();
                end
            end
            default: begin
                if (!key || stage_ticks >= 64'(timer_cfg.timeout)) begin
                    begin_round();
                end else begin
                    bump_ticks();
                end
            end
        endcase
        shown.leds = LED_OFF;
        if (stage == PH_REACT) begin
            shown.leds = LED_GO;
        end else if (stage == PH_HOLD || stage == PH_RELEASE) begin
            shown.leds = timed_out ? LED_MISS : LED_DONE;
            shown.display_on = 1'b1;
            shown.shown_count = reaction_ticks[23:0];
        end
        shown.missed = timed_out;
        return shown;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("%0t ns: result %0d: %s", $time, results_seen, what);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SEED:       timer_cfg.seed = val;
            CFG_DELAY_MIN:  timer_cfg.delay_min = val;
            CFG_DELAY_MASK: timer_cfg.delay_mask = val;
            CFG_TIMEOUT:    timer_cfg.timeout = val;
            CFG_HOLD_TICKS: timer_cfg.hold_ticks = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] seed_val, input logic [31:0] min_val,
                                 input logic [31:0] mask_val, input logic [31:0] timeout_val,
                                 input logic [31:0] hold_val, input logic spare);
        write_reg(CFG_SEED, seed_val);
        write_reg(CFG_DELAY_MIN, min_val);
        write_reg(CFG_DELAY_MASK, mask_val);
        write_reg(CFG_TIMEOUT, timeout_val);
        write_reg(CFG_HOLD_TICKS, hold_val);
        if (spare) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_results();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (pending_displays.size() != 0) @(posedge aclk);
    endtask

    task automatic send_tick(input logic key, input logic fixed, input result_t typed);
        int unsigned gap;
        result_t predicted;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key_pressed <= key;
        do @(posedge aclk); while (!s_ready);
        predicted = timer_tick(key);
        pending_displays.push_back(fixed ? typed : predicted);
        ticks_sent++;
    endtask

    task automatic run_ticks(input int unsigned span, input logic key_runs);
        int unsigned run_left;
        logic run_key;
        run_left = 0;
        run_key = 1'b0;
        repeat (span) begin
            if (run_left == 0) begin
                run_key = 1'($urandom_range(0, 1));
                run_left = key_runs ? $urandom_range(1, 12) : 1;
            end
            run_left--;
            send_tick(run_key, 1'b0, ANY);
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
        end
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'h0000_000F;
            2: return 32'h0000_001F;
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    initial begin : sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = sink_idle ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_round_done) begin
                rounds_seen++;
                if (m_missed) begin
                    misses_seen++;
                end
            end
            if (pending_displays.size() == 0) begin
                report_mismatch("result arrived with no item waiting for it");
            end else begin
                want = pending_displays.pop_front();
                if (m_leds !== want.leds) begin
                    report_mismatch($sformatf("leds 0x%03h, expected 0x%03h", m_leds, want.leds));
                end
                if (m_display_on !== want.display_on) begin
                    report_mismatch($sformatf("display_on %b, expected %b",
                                              m_display_on, want.display_on));
                end
                if (m_shown_count !== want.shown_count) begin
                    report_mismatch($sformatf("shown_count %0d, expected %0d",
                                              m_shown_count, want.shown_count));
                end
                if (m_round_done !== want.round_done) begin
                    report_mismatch($sformatf("round_done %b, expected %b",
                                              m_round_done, want.round_done));
                end
                if (m_missed !== want.missed) begin
                    report_mismatch($sformatf("missed %b, expected %b", m_missed, want.missed));
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("No handshake for %0d cycles, %0d results outstanding.",
                         QUIET_LIMIT, pending_displays.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned phase_no;
        int unsigned span;
        logic [31:0] wrap_next;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An even seed is forced odd, and the spare indexes must not alias a register.
        load_settings(32'hFFFF_FFFE, 32'd0, 32'd0, 32'd3, 32'd1, 1'b1);
        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].key, directed_rows[i].fixed, directed_rows[i].res);
        end

        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_TICKS) begin
            drain_results();
            src_idle = ($urandom_range(0, 2) != 0);
            sink_idle = ($urandom_range(0, 2) != 0);
            if (phase_no == 0) begin
                load_settings($urandom, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
            end else begin
                load_settings($urandom, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 20),
                              pick_mask(), pick_timeout(),
                              ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 12),
                              ($urandom_range(0, 2) == 0));
            end
            span = $urandom_range(25, 70);
            run_ticks(span, 1'($urandom_range(0, 1)));
            random_sent += span;
            phase_no++;
        end

        // The delay sum wraps past 2^32 down to a short wait for the next round.
        drain_results();
        wrap_next = lfsr_step(lfsr_now);
        load_settings($urandom, 32'd4 - wrap_next, 32'hFFFF_FFFF, 32'd6, 32'd2, 1'b0);
        run_ticks(40, 1'b1);

        drain_results();
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 1'b1);
        run_ticks(25, 1'b0);

        drain_results();
        repeat (4) @(posedge aclk);
        $display("Checked %0d results from %0d ticks under %0d register settings.",
                 results_seen, ticks_sent, settings_used);
        $display("Rounds completed: %0d, of which %0d ended by timeout; mismatches: %0d.",
                 rounds_seen, misses_seen, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rtc_pkg.sv
design/rtc_cfg_regs.sv
design/rtc_fsm.sv
design/rtc_out_buf.sv
design/reaction_timer_controller.sv
tb/tb_reaction_timer_controller.sv
